// ----- hdl/xkm_pkg.sv -----
// Shared types, codes and helper functions of the X68000 keyboard and mouse port.
`default_nettype none

package xkm_pkg;

  // Input commands
  localparam logic [1:0] CMD_HOST  = 2'd0;
  localparam logic [1:0] CMD_MOUSE = 2'd1;
  localparam logic [1:0] CMD_KEY   = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  // Result channels
  localparam logic [1:0] CH_KEY   = 2'd0;
  localparam logic [1:0] CH_MOUSE = 2'd1;
  localparam logic [1:0] CH_LED   = 2'd2;

  // Host protocol bytes and nibbles
  localparam logic [7:0] POLL_PREFIX  = 8'h41;
  localparam logic [7:0] POLL_BYTE    = 8'h40;
  localparam logic [3:0] PERIOD_NIB   = 4'h6;
  localparam logic [3:0] DELAY_NIB    = 4'h7;
  localparam logic [3:0] PERIOD_XOR   = 4'h2;

  // Repeat timing
  localparam int unsigned PERIOD_W = 9;
  localparam int unsigned DELAY_W  = 11;
  localparam logic [PERIOD_W-1:0] PERIOD_BASE  = 9'd30;
  localparam logic [DELAY_W-1:0]  DELAY_BASE   = 11'd200;
  localparam logic [DELAY_W-1:0]  DELAY_STEP   = 11'd100;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 9'd500;
  localparam logic [DELAY_W-1:0]  DELAY_RESET  = 11'd500;

  // Reciprocal of three, scaled by 2^9
  localparam logic [15:0] RECIP3 = 16'd171;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [7:0]        host_byte;
    logic [7:0]        mouse_buttons;
    logic signed [7:0] mouse_dx;
    logic signed [7:0] mouse_dy;
    logic [6:0]        key_code;
    logic              key_pressed;
  } xkm_item_t;

  typedef struct packed {
    logic [1:0] channel;
    logic [7:0] data_byte;
    logic       led_caps;
    logic       led_num;
    logic       led_scroll;
  } xkm_result_t;

  // Up to three results caused by one item; entry[0] goes out first
  typedef struct packed {
    logic [1:0]             count;
    xkm_result_t [2:0]      entry;
  } xkm_group_t;

  function automatic xkm_result_t make_result(logic [1:0] ch, logic [7:0] data,
                                              logic caps, logic num, logic scroll);
    xkm_result_t r;
    r.channel    = ch;
    r.data_byte  = data;
    r.led_caps   = caps;
    r.led_num    = num;
    r.led_scroll = scroll;
    return r;
  endfunction

  // Signed divide by three, truncated toward zero
  function automatic logic signed [7:0] div3(logic signed [7:0] v);
    logic [7:0]  mag;
    logic [15:0] prod;
    logic [7:0]  q;
    mag  = v[7] ? (~v + 8'd1) : v;
    prod = {8'd0, mag} * RECIP3;
    q    = {1'b0, prod[15:9]};
    return v[7] ? (~q + 8'd1) : q;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/xkm_in_if.sv -----
// Input channel: one beat carries one command item.
`default_nettype none

interface xkm_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [7:0]        host_byte;
  logic [7:0]        mouse_buttons;
  logic signed [7:0] mouse_dx;
  logic signed [7:0] mouse_dy;
  logic [6:0]        key_code;
  logic              key_pressed;

  modport source (
    output valid, cmd, host_byte, mouse_buttons, mouse_dx, mouse_dy, key_code, key_pressed,
    input  ready
  );
  modport sink (
    input  valid, cmd, host_byte, mouse_buttons, mouse_dx, mouse_dy, key_code, key_pressed,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/xkm_out_if.sv -----
// Output channel: one beat carries one transmit byte or LED update.
`default_nettype none

interface xkm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] channel;
  logic [7:0] data_byte;
  logic       led_caps;
  logic       led_num;
  logic       led_scroll;
  logic       last;

  modport source (
    output valid, channel, data_byte, led_caps, led_num, led_scroll, last,
    input  ready
  );
  modport sink (
    input  valid, channel, data_byte, led_caps, led_num, led_scroll, last,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/xkm_core.sv -----
// Port state and per-item decode: builds the result group and updates state.
`default_nettype none

module xkm_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire xkm_pkg::xkm_item_t item,
  input  wire logic               take,
  output xkm_pkg::xkm_group_t     grp
);

  logic [7:0]                    previous_host_byte, previous_host_byte_next;
  logic [15:0]                   accum_dx, accum_dx_next;
  logic [15:0]                   accum_dy, accum_dy_next;
  logic [7:0]                    held_buttons, held_buttons_next;
  logic [6:0]                    held_scan_code, held_scan_code_next;
  logic                          key_is_held, key_is_held_next;
  logic [31:0]                   press_time_ms, press_time_ms_next;
  logic [31:0]                   now_ms, now_ms_next;
  logic [xkm_pkg::PERIOD_W-1:0]  repeat_period_ms, repeat_period_ms_next;
  logic [xkm_pkg::DELAY_W-1:0]   repeat_delay_ms, repeat_delay_ms_next;
  logic [xkm_pkg::PERIOD_W-1:0]  period_counter, period_counter_next;

  logic                          poll;
  logic [7:0]                    hdr;
  logic                          dx_hi, dx_lo, dy_hi, dy_lo;
  logic [3:0]                    nib_x;
  logic signed [7:0]             qx, qy;
  logic [xkm_pkg::PERIOD_W-1:0]  pc_inc;
  logic [31:0]                   elapsed;
  xkm_pkg::xkm_result_t          key_res;

  assign poll  = (item.host_byte == xkm_pkg::POLL_BYTE) &&
                 (previous_host_byte == xkm_pkg::POLL_PREFIX);
  assign dx_hi = !accum_dx[15] && (accum_dx[14:7] != 8'h00);
  assign dx_lo =  accum_dx[15] && (accum_dx[14:7] != 8'hFF);
  assign dy_hi = !accum_dy[15] && (accum_dy[14:7] != 8'h00);
  assign dy_lo =  accum_dy[15] && (accum_dy[14:7] != 8'hFF);
  assign hdr   = held_buttons | {dy_lo, dy_hi, dx_lo, dx_hi, 4'b0000};
  assign nib_x = item.host_byte[3:0] ^ xkm_pkg::PERIOD_XOR;
  assign qx    = xkm_pkg::div3(item.mouse_dx);
  assign qy    = xkm_pkg::div3(item.mouse_dy);
  assign pc_inc  = period_counter + 9'd1;
  assign elapsed = now_ms + 32'd1 - press_time_ms;

  always_comb begin
    previous_host_byte_next = previous_host_byte;
    accum_dx_next           = accum_dx;
    accum_dy_next           = accum_dy;
    held_buttons_next       = held_buttons;
    held_scan_code_next     = held_scan_code;
    key_is_held_next        = key_is_held;
    press_time_ms_next      = press_time_ms;
    now_ms_next             = now_ms;
    repeat_period_ms_next   = repeat_period_ms;
    repeat_delay_ms_next    = repeat_delay_ms;
    period_counter_next     = period_counter;
    grp                     = '0;
    key_res                 = xkm_pkg::make_result(xkm_pkg::CH_KEY, 8'h00, 1'b0, 1'b0, 1'b0);

    unique case (item.cmd)
      xkm_pkg::CMD_HOST: begin
        if (poll) begin
          grp.count    = 2'd3;
          grp.entry[0] = xkm_pkg::make_result(xkm_pkg::CH_MOUSE, hdr, 1'b0, 1'b0, 1'b0);
          grp.entry[1] = xkm_pkg::make_result(xkm_pkg::CH_MOUSE, accum_dx[7:0],
                                              1'b0, 1'b0, 1'b0);
          grp.entry[2] = xkm_pkg::make_result(xkm_pkg::CH_MOUSE, accum_dy[7:0],
                                              1'b0, 1'b0, 1'b0);
          accum_dx_next = '0;
          accum_dy_next = '0;
        end else if (item.host_byte[7]) begin
          grp.count    = 2'd1;
          grp.entry[0] = xkm_pkg::make_result(xkm_pkg::CH_LED, item.host_byte,
                                              item.host_byte[4], item.host_byte[3],
                                              item.host_byte[6]);
        end
        if (item.host_byte[7:4] == xkm_pkg::PERIOD_NIB) begin
          repeat_period_ms_next = xkm_pkg::PERIOD_BASE + {3'b000, nib_x, 2'b00}
                                  + {5'b00000, nib_x};
        end
        if (item.host_byte[7:4] == xkm_pkg::DELAY_NIB) begin
          repeat_delay_ms_next = xkm_pkg::DELAY_BASE
                                 + ({7'd0, item.host_byte[3:0]} * xkm_pkg::DELAY_STEP);
        end
        previous_host_byte_next = item.host_byte;
      end
      xkm_pkg::CMD_MOUSE: begin
        accum_dx_next     = accum_dx + {{8{qx[7]}}, qx};
        accum_dy_next     = accum_dy + {{8{qy[7]}}, qy};
        held_buttons_next = item.mouse_buttons;
      end
      xkm_pkg::CMD_KEY: begin
        if (item.key_code != 7'd0) begin
          grp.count = 2'd1;
          if (item.key_pressed) begin
            key_res.data_byte   = {1'b0, item.key_code};
            held_scan_code_next = item.key_code;
            press_time_ms_next  = now_ms;
            key_is_held_next    = 1'b1;
          end else begin
            key_res.data_byte = {1'b1, item.key_code};
            if (item.key_code == held_scan_code) begin
              key_is_held_next = 1'b0;
            end
          end
          grp.entry[0] = key_res;
        end
      end
      xkm_pkg::CMD_TICK: begin
        now_ms_next         = now_ms + 32'd1;
        period_counter_next = pc_inc;
        if (pc_inc >= repeat_period_ms) begin
          period_counter_next = '0;
          if (key_is_held && (elapsed >= {21'd0, repeat_delay_ms})) begin
            grp.count         = 2'd1;
            key_res.data_byte = {1'b0, held_scan_code};
            grp.entry[0]      = key_res;
          end
        end
      end
      default: begin
        grp = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_host_byte <= '0;
      accum_dx           <= '0;
      accum_dy           <= '0;
      held_buttons       <= '0;
      held_scan_code     <= '0;
      key_is_held        <= 1'b0;
      press_time_ms      <= '0;
      now_ms             <= '0;
      repeat_period_ms   <= xkm_pkg::PERIOD_RESET;
      repeat_delay_ms    <= xkm_pkg::DELAY_RESET;
      period_counter     <= '0;
    end else if (take) begin
      previous_host_byte <= previous_host_byte_next;
      accum_dx           <= accum_dx_next;
      accum_dy           <= accum_dy_next;
      held_buttons       <= held_buttons_next;
      held_scan_code     <= held_scan_code_next;
      key_is_held        <= key_is_held_next;
      press_time_ms      <= press_time_ms_next;
      now_ms             <= now_ms_next;
      repeat_period_ms   <= repeat_period_ms_next;
      repeat_delay_ms    <= repeat_delay_ms_next;
      period_counter     <= period_counter_next;
    end
  end

`ifndef SYNTH
  a_poll_clears: assert property (@(posedge clk) disable iff (rst)
    (take && item.cmd == xkm_pkg::CMD_HOST && poll) |=> (accum_dx == 16'd0 && accum_dy == 16'd0))
    else $error("accumulators not cleared after poll");
  a_counter_below_period: assert property (@(posedge clk) disable iff (rst)
    (take && item.cmd == xkm_pkg::CMD_TICK && grp.count != 2'd0) |=> (period_counter == '0))
    else $error("repeat fired without clearing period counter");
`endif

endmodule

`default_nettype wire

// ----- hdl/xkm_serializer.sv -----
// Result buffer: holds one group and sends its entries one beat at a time.
`default_nettype none

module xkm_serializer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire xkm_pkg::xkm_group_t grp,
  input  wire logic                load_valid,
  output logic                     load_ready,
  xkm_out_if.source                result
);

  logic [1:0]                  cnt;
  xkm_pkg::xkm_result_t [2:0]  ent;
  logic                        pop;
  logic                        load;

  assign pop        = (cnt != 2'd0) && result.ready;
  assign load       = load_valid && (grp.count != 2'd0);
  assign load_ready = (cnt == 2'd0) || ((cnt == 2'd1) && result.ready);

  assign result.valid      = (cnt != 2'd0);
  assign result.channel    = ent[0].channel;
  assign result.data_byte  = ent[0].data_byte;
  assign result.led_caps   = ent[0].led_caps;
  assign result.led_num    = ent[0].led_num;
  assign result.led_scroll = ent[0].led_scroll;
  assign result.last       = (cnt == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= grp.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Load a new group, else advance the queue head on each beat taken
  always_ff @(posedge clk) begin
    if (load) begin
      ent <= grp.entry;
    end else if (pop) begin
      ent[0] <= ent[1];
      ent[1] <= ent[2];
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_valid |-> load_ready)
    else $error("group loaded while entries still pending");
  a_drain_ends: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && result.last && !load) |=> !result.valid)
    else $error("valid held after final beat");
`endif

endmodule

`default_nettype wire

// ----- hdl/x68k_keyboard_mouse_port.sv -----
// Top level of the X68000 keyboard and mouse port device side.
//
// Channels: "item" takes one command beat (host byte, mouse report, key
// event or millisecond tick); "result" sends transmit bytes and LED updates,
// with last set on the final beat caused by an item.
// Path: an accepted item lands in the input register, is decoded there and
// its results load the output buffer once the buffer can take them; the
// buffer then presents the first result beat.
// Throughput: one item per cycle while result.ready is high, except a mouse
// poll, which occupies the output buffer for its three beats.
// The output buffer holds one group of up to three results; the next group
// loads in the same cycle the final beat of the current one is taken.
// Reset: rst (synchronous) clears the accumulators, key and timer state,
// sets the repeat period and delay to 500 ms and empties both stages.
// Stall: while result.ready is low, the buffer holds its beat, the input
// register holds one decoded-but-waiting item and item.ready drops only
// once that register is occupied.
`default_nettype none

module x68k_keyboard_mouse_port (
  input  wire logic clk,
  input  wire logic rst,
  xkm_in_if.sink    item,
  xkm_out_if.source result
);

  xkm_pkg::xkm_item_t  item_q;
  logic                item_vld;
  logic                load_ready;
  logic                adv;
  xkm_pkg::xkm_group_t grp;

  // Hand the registered item to decode when the output buffer can take it
  assign adv        = item_vld && load_ready;
  assign item.ready = !item_vld || load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (item.valid && item.ready) begin
      item_vld <= 1'b1;
    end else if (adv) begin
      item_vld <= 1'b0;
    end
  end

  // Capture the payload of each accepted beat
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      item_q.cmd           <= item.cmd;
      item_q.host_byte     <= item.host_byte;
      item_q.mouse_buttons <= item.mouse_buttons;
      item_q.mouse_dx      <= item.mouse_dx;
      item_q.mouse_dy      <= item.mouse_dy;
      item_q.key_code      <= item.key_code;
      item_q.key_pressed   <= item.key_pressed;
    end
  end

  xkm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .item (item_q),
    .take (adv),
    .grp  (grp)
  );

  xkm_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .grp        (grp),
    .load_valid (adv),
    .load_ready (load_ready),
    .result     (result)
  );

endmodule

`default_nettype wire
